/* rtl/nrp_pkg.sv */
// Shared types, constants and a helper function of the RMC position parser.
package nrp_pkg;

	localparam int unsigned FRAC_DIGITS_DEF = 5;
	localparam int unsigned SPEED_CHARS_DEF = 8;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [19:0] MICRO = 20'd1000000;
	localparam logic [3:0] LAT_DEG_DIGITS = 4'd2;
	localparam logic [3:0] LON_DEG_DIGITS = 4'd3;

	typedef enum logic [1:0] {
		CMD_LAT  = 2'd0,
		CMD_LON  = 2'd1,
		CMD_EMIT = 2'd2
	} cmd_kind_t;

	// One unit of work handed from the byte parser to the converter.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [9:0]  deg;
		logic [3:0]  char_idx;
		logic [19:0] frac;
		logic [2:0]  frac_cnt;
		logic [6:0]  whole_min;
		logic        negative;
		logic        status;
		logic [63:0] speed_text;
		logic [3:0]  speed_len;
		logic        speed_over;
	} cmd_t;

	function automatic logic [19:0] pow10(input logic [2:0] n);
		logic [19:0] r;
		case (n)
			3'd0: r = 20'd1;
			3'd1: r = 20'd10;
			3'd2: r = 20'd100;
			3'd3: r = 20'd1000;
			3'd4: r = 20'd10000;
			3'd5: r = 20'd100000;
			3'd6: r = 20'd1000000;
			default: r = 20'd1;
		endcase
		return r;
	endfunction

endpackage

/* rtl/nrp_front.sv */
// Byte parser: walks the sentence fields and queues conversion and emit work.
module nrp_front #(
	parameter int unsigned FRAC_DIGITS = nrp_pkg::FRAC_DIGITS_DEF,
	parameter int unsigned SPEED_CHARS = nrp_pkg::SPEED_CHARS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rx_valid,
	output logic           rx_ready,
	input  logic [7:0]     rx_byte,
	input  logic           q_full,
	output logic           q_push,
	output nrp_pkg::cmd_t  q_data
);
	import nrp_pkg::*;

	typedef enum logic [3:0] {
		PH_SYNC   = 4'd0,
		PH_MSGID  = 4'd1,
		PH_TIME   = 4'd2,
		PH_STATUS = 4'd3,
		PH_LAT    = 4'd4,
		PH_NS     = 4'd5,
		PH_LON    = 4'd6,
		PH_EW     = 4'd7,
		PH_SPEED  = 4'd8
	} phase_t;

	localparam logic [2:0] FRAC_MAX = 3'(FRAC_DIGITS);
	localparam logic [3:0] SPEED_MAX = 4'(SPEED_CHARS);

	phase_t      phase_q, phase_d;
	logic        status_q, status_d, south_q, south_d, west_q, west_d;
	logic [3:0]  idx_q, idx_d;
	logic [9:0]  deg_q, deg_d;
	logic [19:0] frac_q, frac_d;
	logic [2:0]  fcnt_q, fcnt_d;
	logic [6:0]  wm_q, wm_d;
	logic [1:0]  mode_q, mode_d;
	logic        hemi_q, hemi_d;
	logic [63:0] sbuf_q, sbuf_d;
	logic [3:0]  scnt_q, scnt_d;
	logic        sover_q, sover_d;

	logic        accept, comma, isdig;
	logic [3:0]  digit, dd;
	logic [9:0]  wm_next;

	assign rx_ready = !q_full;
	assign accept = rx_valid && rx_ready;
	assign comma = (rx_byte == 8'h2C);
	assign isdig = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
	assign digit = isdig ? 4'(rx_byte - 8'h30) : 4'd0;
	assign dd = (phase_q == PH_LAT) ? LAT_DEG_DIGITS : LON_DEG_DIGITS;
	assign wm_next = 10'(wm_q) * 10'd10 + 10'(digit);

	always_comb begin
		phase_d = phase_q;
		status_d = status_q;
		south_d = south_q;
		west_d = west_q;
		idx_d = idx_q;
		deg_d = deg_q;
		frac_d = frac_q;
		fcnt_d = fcnt_q;
		wm_d = wm_q;
		mode_d = mode_q;
		hemi_d = hemi_q;
		sbuf_d = sbuf_q;
		scnt_d = scnt_q;
		sover_d = sover_q;
		q_push = 1'b0;
		q_data = '0;
		q_data.deg = deg_q;
		q_data.char_idx = idx_q;
		q_data.frac = frac_q;
		q_data.frac_cnt = fcnt_q;
		q_data.whole_min = wm_q;
		q_data.status = status_q;
		q_data.speed_text = sbuf_q;
		q_data.speed_len = scnt_q;
		q_data.speed_over = sover_q;
		case (phase_q)
			PH_SYNC: if (rx_byte == 8'h24) phase_d = PH_MSGID;
			PH_MSGID: if (comma) phase_d = PH_TIME;
			PH_TIME: if (comma) phase_d = PH_STATUS;
			PH_STATUS: begin
				if (comma) begin
					phase_d = PH_LAT;
					idx_d = '0; deg_d = '0; frac_d = '0; fcnt_d = '0;
					wm_d = '0; mode_d = '0; hemi_d = 1'b0;
				end else begin
					status_d = (rx_byte == 8'h41);
				end
			end
			PH_LAT, PH_LON: begin
				if (comma) begin
					phase_d = (phase_q == PH_LAT) ? PH_NS : PH_EW;
					hemi_d = 1'b0;
				end else begin
					if (idx_q < dd) begin
						deg_d = 10'(deg_q * 10'd10 + 10'(digit));
					end else if (mode_q == 2'd0) begin
						if (isdig) wm_d = (wm_next > 10'd99) ? 7'd99 : wm_next[6:0];
						else if (rx_byte == 8'h2E) mode_d = 2'd1;
						else mode_d = 2'd2;
					end else if (mode_q == 2'd1) begin
						if (isdig) begin
							if (fcnt_q < FRAC_MAX) begin
								frac_d = 20'(frac_q * 20'd10 + 20'(digit));
								fcnt_d = fcnt_q + 3'd1;
							end
						end else begin
							mode_d = 2'd2;
						end
					end
					if (idx_q != 4'd15) idx_d = idx_q + 4'd1;
				end
			end
			PH_NS: begin
				if (comma) begin
					q_push = accept && hemi_q;
					q_data.kind = CMD_LAT;
					q_data.negative = south_q;
					phase_d = PH_LON;
					idx_d = '0; deg_d = '0; frac_d = '0; fcnt_d = '0;
					wm_d = '0; mode_d = '0; hemi_d = 1'b0;
				end else begin
					south_d = (rx_byte != 8'h4E);
					hemi_d = 1'b1;
				end
			end
			PH_EW: begin
				if (comma) begin
					q_push = accept && hemi_q;
					q_data.kind = CMD_LON;
					q_data.negative = west_q;
					phase_d = PH_SPEED;
					sbuf_d = '0; scnt_d = '0; sover_d = 1'b0;
				end else begin
					west_d = (rx_byte != 8'h45);
					hemi_d = 1'b1;
				end
			end
			PH_SPEED: begin
				if (comma) begin
					q_push = accept;
					q_data.kind = CMD_EMIT;
					phase_d = PH_SYNC;
				end else if (scnt_q < SPEED_MAX && scnt_q < 4'd8) begin
					sbuf_d[{scnt_q[2:0], 3'b000} +: 8] = rx_byte;
					scnt_d = scnt_q + 4'd1;
				end else begin
					sover_d = 1'b1;
				end
			end
			default: phase_d = PH_SYNC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			status_q <= 1'b0; south_q <= 1'b0; west_q <= 1'b0;
			idx_q <= '0; deg_q <= '0; frac_q <= '0; fcnt_q <= '0;
			wm_q <= '0; mode_q <= '0; hemi_q <= 1'b0;
			sbuf_q <= '0; scnt_q <= '0; sover_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			status_q <= status_d; south_q <= south_d; west_q <= west_d;
			idx_q <= idx_d; deg_q <= deg_d; frac_q <= frac_d; fcnt_q <= fcnt_d;
			wm_q <= wm_d; mode_q <= mode_d; hemi_q <= hemi_d;
			sbuf_q <= sbuf_d; scnt_q <= scnt_d; sover_q <= sover_d;
		end
	end

endmodule

/* rtl/nrp_queue.sv */
// Short command queue between the byte parser and the converter.
module nrp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nrp_pkg::cmd_t  wdata,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output nrp_pkg::cmd_t  rdata
);
	import nrp_pkg::*;

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign full = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop) rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue read while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(QUEUE_DEPTH))
		else $error("queue count above depth");
`endif

endmodule

/* rtl/nrp_back.sv */
// Converter: turns coordinate fields into micro-degrees and drives the result register.
module nrp_back #(
	parameter int unsigned FRAC_DIGITS = nrp_pkg::FRAC_DIGITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  nrp_pkg::cmd_t  q_data,
	output logic           q_pop,
	output logic           res_valid,
	input  logic           res_ready,
	output logic           fix_valid,
	output logic [27:0]    latitude_udeg,
	output logic [30:0]    longitude_udeg,
	output logic [63:0]    speed_text,
	output logic [3:0]     speed_length,
	output logic           speed_overflow
);
	import nrp_pkg::*;

	localparam logic [19:0] SCALE = pow10(3'(FRAC_DIGITS));
	// micro-minutes per fraction unit; the fraction scale cancels out of the division
	localparam logic [19:0] UNIT_MUL = pow10(3'(6 - FRAC_DIGITS));
	localparam logic [26:0] HALF_MIN = 27'd30;
	// ceil(2^29 / 15): exact quotient by 15 for numerators below 2^25
	localparam logic [25:0] RECIP_15 = 26'd35791395;
	localparam int unsigned RECIP_SHIFT = 29;
	localparam int unsigned QW = 21;
	localparam logic [QW-1:0] QUOT_MAX = 21'd1666667;

	typedef enum logic [2:0] {
		B_IDLE, B_MUL1, B_MUL2, B_MUL3, B_DIV, B_DONE
	} bstate_t;

	bstate_t     state_q;
	cmd_t        cmd_q;
	logic [9:0]  deg_s_q;
	logic [19:0] frac_s_q;
	logic [26:0] scaled_q;
	logic [26:0] num_q;
	logic [29:0] degm_q;
	logic [QW-1:0] quot_q;
	logic [27:0] lat_q;
	logic [30:0] lon_q;
	logic        out_v_q;

	logic [3:0]  dd;
	logic [9:0]  deg_fac;
	logic [50:0] recip_prod;
	logic [30:0] mag, mag_n;
	logic        take_emit, load_res;

	assign dd = (cmd_q.kind == CMD_LON) ? LON_DEG_DIGITS : LAT_DEG_DIGITS;
	assign deg_fac = (cmd_q.char_idx < dd) ? 10'(pow10(3'(dd - cmd_q.char_idx))) : 10'd1;
	// divide by 60 as a shift by 2 and a reciprocal multiply by 1/15
	assign recip_prod = 51'(num_q[26:2]) * 51'(RECIP_15);
	assign mag = {1'b0, degm_q} + 31'(quot_q);
	assign mag_n = cmd_q.negative ? 31'd0 - mag : mag;
	assign take_emit = (q_data.kind == CMD_EMIT) && (!out_v_q || res_ready);
	assign q_pop = (state_q == B_IDLE) && !q_empty &&
		((q_data.kind != CMD_EMIT) || take_emit);
	assign load_res = q_pop && (q_data.kind == CMD_EMIT);
	assign res_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_v_q <= 1'b0;
			lat_q <= '0;
			lon_q <= '0;
			cmd_q <= '0;
			deg_s_q <= '0;
			frac_s_q <= '0;
			scaled_q <= '0;
			num_q <= '0;
			degm_q <= '0;
			quot_q <= '0;
			fix_valid <= 1'b0;
			latitude_udeg <= '0;
			longitude_udeg <= '0;
			speed_text <= '0;
			speed_length <= '0;
			speed_overflow <= 1'b0;
		end else begin
			if (load_res) out_v_q <= 1'b1;
			else if (res_ready) out_v_q <= 1'b0;
			if (load_res) begin
				fix_valid <= q_data.status;
				latitude_udeg <= lat_q;
				longitude_udeg <= lon_q;
				speed_text <= q_data.speed_text;
				speed_length <= q_data.speed_len;
				speed_overflow <= q_data.speed_over;
			end
			case (state_q)
				B_IDLE: begin
					if (q_pop && (q_data.kind != CMD_EMIT)) begin
						cmd_q <= q_data;
						state_q <= B_MUL1;
					end
				end
				B_MUL1: begin
					deg_s_q <= 10'(cmd_q.deg * deg_fac);
					frac_s_q <= 20'(cmd_q.frac * pow10(3'(FRAC_DIGITS) - cmd_q.frac_cnt));
					state_q <= B_MUL2;
				end
				B_MUL2: begin
					scaled_q <= 27'(cmd_q.whole_min) * 27'(SCALE) + 27'(frac_s_q);
					state_q <= B_MUL3;
				end
				B_MUL3: begin
					num_q <= 27'(scaled_q) * 27'(UNIT_MUL) + HALF_MIN;
					degm_q <= 30'(deg_s_q) * 30'(MICRO);
					state_q <= B_DIV;
				end
				B_DIV: begin
					quot_q <= recip_prod[RECIP_SHIFT +: QW];
					state_q <= B_DONE;
				end
				B_DONE: begin
					if (cmd_q.kind == CMD_LON) lon_q <= mag_n;
					else lat_q <= mag_n[27:0];
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == B_IDLE)
		else $error("command taken while converting");
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DONE |-> quot_q <= QUOT_MAX)
		else $error("minute quotient out of range");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |=> state_q == B_DONE)
		else $error("division did not finish");
`endif

endmodule

/* rtl/nmea_rmc_position_parser.sv */
// Top level of the NMEA RMC position parser.
// Usage:
//  - rx channel (rx_valid/rx_ready/rx_byte) takes one sentence character per
//    transfer, one per cycle when the command queue has room.
//  - res channel (res_valid/res_ready) delivers one result per sentence, at the
//    comma that ends the speed field: status, latitude and longitude in signed
//    micro-degrees, and the speed text with its length and overflow flag.
//  - The byte parser updates its field state once per accepted character and
//    posts work to a four-entry queue. The converter turns each coordinate into
//    micro-degrees by taking the command, three multiply steps, one reciprocal
//    multiply for the division by 60 and one store, and takes no new command
//    until it is back in idle.
//  - An emit command loads the result register at the edge that takes it from
//    the queue, so res_valid rises after the emit command has passed the queue,
//    when the converter is idle and the result register is free.
//  - rx_ready drops only while the queue is full; when res_ready is low the
//    finished result holds in the output register and parsing goes on until
//    the queue fills.
//  - Reset clears all parse state, stored coordinates and the queue; the
//    parser then waits for a dollar sign.
module nmea_rmc_position_parser #(
	parameter int unsigned FRAC_DIGITS = nrp_pkg::FRAC_DIGITS_DEF,
	parameter int unsigned SPEED_CHARS = nrp_pkg::SPEED_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        fix_valid,
	output logic signed [27:0] latitude_udeg,
	output logic signed [30:0] longitude_udeg,
	output logic [63:0] speed_text,
	output logic [3:0]  speed_length,
	output logic        speed_overflow
);
	import nrp_pkg::*;

	cmd_t push_data, pop_data;
	logic push, pop, full, empty;

	nrp_front #(.FRAC_DIGITS(FRAC_DIGITS), .SPEED_CHARS(SPEED_CHARS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
		.q_full(full), .q_push(push), .q_data(push_data)
	);

	nrp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(push_data), .full(full),
		.pop(pop), .empty(empty), .rdata(pop_data)
	);

	nrp_back #(.FRAC_DIGITS(FRAC_DIGITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(empty), .q_data(pop_data), .q_pop(pop),
		.res_valid(res_valid), .res_ready(res_ready),
		.fix_valid(fix_valid), .latitude_udeg(latitude_udeg),
		.longitude_udeg(longitude_udeg), .speed_text(speed_text),
		.speed_length(speed_length), .speed_overflow(speed_overflow)
	);

endmodule

/* tb/sv/tb_nmea_rmc_position_parser.sv */
// Testbench for the NMEA RMC position parser: byte stream in, parsed fixes checked.
module tb_nmea_rmc_position_parser;

	localparam int FRAC_N  = 5;
	localparam int SPD_MAX = 8;

	typedef enum int {
		PH_SYNC, PH_MSGID, PH_TIME, PH_STATUS, PH_LAT, PH_NS, PH_LON, PH_EW, PH_SPEED
	} phase_e;

	typedef struct packed {
		logic        fix;
		logic [27:0] lat;
		logic [30:0] lon;
		logic [63:0] spd;
		logic [3:0]  spd_len;
		logic        spd_over;
	} fix_rec_t;

	logic        clk;
	logic        arst_n;
	logic        rx_valid;
	logic        rx_ready;
	logic [7:0]  rx_byte;
	logic        res_valid;
	logic        res_ready;
	logic        fix_valid;
	logic signed [27:0] latitude_udeg;
	logic signed [30:0] longitude_udeg;
	logic [63:0] speed_text;
	logic [3:0]  speed_length;
	logic        speed_overflow;

	nmea_rmc_position_parser u_top (
		.clk(clk), .arst_n(arst_n),
		.rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
		.res_valid(res_valid), .res_ready(res_ready),
		.fix_valid(fix_valid), .latitude_udeg(latitude_udeg),
		.longitude_udeg(longitude_udeg), .speed_text(speed_text),
		.speed_length(speed_length), .speed_overflow(speed_overflow)
	);

	// parser mirror state
	phase_e      ph;
	logic        st_flag, s_flag, w_flag, hemi_seen, spd_ov;
	int unsigned char_idx, deg_acc, min_frac, frac_cnt, whole_min, min_mode;
	logic [27:0] lat_val;
	logic [30:0] lon_val;
	logic [63:0] spd_buf;
	int unsigned spd_cnt;

	logic [7:0] pending_bytes[$];
	fix_rec_t   expected_fixes[$];
	int         mismatches;
	int         fixes_seen;
	bit         stim_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic coord_clear();
		char_idx = 0; deg_acc = 0; min_frac = 0; frac_cnt = 0;
		whole_min = 0; min_mode = 0; hemi_seen = 1'b0;
	endtask

	task automatic coord_take(input logic [7:0] c, input int unsigned ndeg);
		logic        dig;
		int unsigned d;
		dig = (c >= "0" && c <= "9");
		d = dig ? c - "0" : 0;
		if (char_idx < ndeg) begin
			deg_acc = deg_acc * 10 + d;
		end else if (min_mode == 0) begin
			if (dig) begin
				whole_min = whole_min * 10 + d;
				if (whole_min > 99) whole_min = 99;
			end else if (c == ".") begin
				min_mode = 1;
			end else begin
				min_mode = 2;
			end
		end else if (min_mode == 1) begin
			if (dig) begin
				if (frac_cnt < FRAC_N) begin
					min_frac = min_frac * 10 + d;
					frac_cnt++;
				end
			end else begin
				min_mode = 2;
			end
		end
		if (char_idx < 15) char_idx++;
	endtask

	function automatic longint unsigned udeg_of(input int unsigned ndeg, input logic neg);
		longint unsigned deg, p, fr, mag;
		deg = deg_acc; p = 1; fr = min_frac;
		for (int i = char_idx; i < ndeg; i++) deg *= 10;
		for (int i = 0; i < FRAC_N; i++) p *= 10;
		for (int i = frac_cnt; i < FRAC_N; i++) fr *= 10;
		mag = deg * 1000000 + ((whole_min * p + fr) * 1000000 + 30 * p) / (60 * p);
		if (neg) mag = 0 - mag;
		return mag;
	endfunction

	task automatic parse_byte(input logic [7:0] c);
		logic     comma;
		fix_rec_t r;
		comma = (c == ",");
		case (ph)
			PH_SYNC: if (c == "$") ph = PH_MSGID;
			PH_MSGID: if (comma) ph = PH_TIME;
			PH_TIME: if (comma) ph = PH_STATUS;
			PH_STATUS: if (comma) begin
				ph = PH_LAT;
				coord_clear();
			end else begin
				st_flag = (c == "A");
			end
			PH_LAT: if (comma) begin
				ph = PH_NS;
				hemi_seen = 1'b0;
			end else begin
				coord_take(c, 2);
			end
			PH_NS: if (comma) begin
				if (hemi_seen) lat_val = 28'(udeg_of(2, s_flag));
				ph = PH_LON;
				coord_clear();
			end else begin
				s_flag = (c != "N");
				hemi_seen = 1'b1;
			end
			PH_LON: if (comma) begin
				ph = PH_EW;
				hemi_seen = 1'b0;
			end else begin
				coord_take(c, 3);
			end
			PH_EW: if (comma) begin
				if (hemi_seen) lon_val = 31'(udeg_of(3, w_flag));
				ph = PH_SPEED;
				spd_buf = '0; spd_cnt = 0; spd_ov = 1'b0;
			end else begin
				w_flag = (c != "E");
				hemi_seen = 1'b1;
			end
			PH_SPEED: if (comma) begin
				r.fix = st_flag; r.lat = lat_val; r.lon = lon_val;
				r.spd = spd_buf; r.spd_len = 4'(spd_cnt); r.spd_over = spd_ov;
				expected_fixes.push_back(r);
				ph = PH_SYNC;
			end else if (spd_cnt < SPD_MAX) begin
				spd_buf[8*spd_cnt +: 8] = c;
				spd_cnt++;
			end else begin
				spd_ov = 1'b1;
			end
			default: ph = PH_SYNC;
		endcase
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
	endtask

	function automatic string digits(input int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
		return s;
	endfunction

	function automatic string rand_char_str(input int n);
		string s;
		byte   b;
		s = "";
		for (int i = 0; i < n; i++) begin
			b = $urandom_range(0, 255);
			if (b == ",") b = "x";
			s = {s, string'(b)};
		end
		return s;
	endfunction

	function automatic string rand_coord(input int ndeg);
		string s;
		int    k;
		k = $urandom_range(0, 19);
		if (k == 0) return "";
		if (k == 1) return rand_char_str($urandom_range(1, 16));
		s = {digits(ndeg), digits(2)};
		if (k == 2) return digits($urandom_range(1, ndeg + 4));
		if (k == 3) return {s, "x", digits(2)};
		if ($urandom_range(0, 5) != 0) s = {s, ".", digits($urandom_range(0, 8))};
		return s;
	endfunction

	function automatic string rand_sentence();
		string s, st, h1, h2;
		int    r;
		r = $urandom_range(0, 9);
		st = (r < 6) ? "A" : (r < 8) ? "V" : (r == 8) ? "" : rand_char_str(2);
		r = $urandom_range(0, 9);
		h1 = (r < 4) ? "N" : (r < 8) ? "S" : (r == 8) ? "" : rand_char_str(2);
		r = $urandom_range(0, 9);
		h2 = (r < 4) ? "E" : (r < 8) ? "W" : (r == 8) ? "" : rand_char_str(2);
		s = {"$GPRMC,", digits(6), ".00,", st, ",", rand_coord(2), ",", h1, ",",
			rand_coord(3), ",", h2, ",",
			rand_char_str($urandom_range(0, 3) == 0 ? $urandom_range(0, 12)
				: $urandom_range(1, 6)), ","};
		return s;
	endfunction

	// stimulus
	initial begin
		int noise;
		push_str("$GPRMC,123519,A,0000.00000,N,00000.00000,E,0.0,");
		push_str("$GPRMC,1,A,9959.99999,S,99959.999999,W,12345678,");
		push_str("$GPRMC,,V,4807.038,N,01131.000,E,123456789AB,");
		push_str("$GPRMC,,,4,N,12,E,,");
		push_str("$GPRMC,$,A,12a4.5,X,1234.5.6,Y,$$,");
		push_str("$GPRMC,,A,4807.038,,01131,,022.4,");
		push_str("$,,V,12999,S,123ab,W,1,");
		for (int i = 0; i < 4; i++) pending_bytes.push_back(8'hFF >> i);
		while (pending_bytes.size() < 1450) begin
			noise = $urandom_range(0, 9);
			if (noise == 0) push_str(rand_char_str($urandom_range(1, 5)));
			push_str(rand_sentence());
		end
	end

	// transfer seen at the last rising edge
	logic rx_fire;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) rx_fire <= 1'b0;
		else rx_fire <= rx_valid && rx_ready;
	end

	// driver
	int unsigned hold_off;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_byte  <= '0;
			hold_off <= 0;
		end else if (!rx_valid || rx_fire) begin
			// advance only once the held byte has been transferred
			if (hold_off != 0) begin
				rx_valid <= 1'b0;
				hold_off <= hold_off - 1;
			end else if (pending_bytes.size() != 0) begin
				rx_valid <= 1'b1;
				rx_byte  <= pending_bytes.pop_front();
				hold_off <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// res_ready gaps
	int unsigned stall;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall     <= 0;
		end else if (stall != 0) begin
			res_ready <= 1'b0;
			stall     <= stall - 1;
		end else begin
			res_ready <= 1'b1;
			stall     <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
		end
	end

	// input monitor feeds the predictor
	always @(posedge clk) begin
		if (arst_n && rx_valid && rx_ready) parse_byte(rx_byte);
	end

	// result checker
	always @(posedge clk) begin
		fix_rec_t e;
		if (arst_n && res_valid && res_ready) begin
			fixes_seen <= fixes_seen + 1;
			if (expected_fixes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer");
			end else begin
				e = expected_fixes.pop_front();
				if (e.fix !== fix_valid || e.lat !== latitude_udeg ||
				    e.lon !== longitude_udeg || e.spd !== speed_text ||
				    e.spd_len !== speed_length || e.spd_over !== speed_overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp fix=%0b lat=%0d lon=%0d spd=%h len=%0d ov=%0b",
							e.fix, $signed(e.lat), $signed(e.lon), e.spd, e.spd_len,
							e.spd_over, "\n          got fix=%0b lat=%0d lon=%0d spd=%h",
							fix_valid, latitude_udeg, longitude_udeg, speed_text,
							" len=%0d ov=%0b", speed_length, speed_overflow);
				end
			end
		end
	end

	// reset and end of run
	initial begin
		ph = PH_SYNC; st_flag = 0; s_flag = 0; w_flag = 0; spd_ov = 0;
		coord_clear();
		lat_val = '0; lon_val = '0; spd_buf = '0; spd_cnt = 0;
		mismatches = 0; fixes_seen = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_bytes.size() == 0 && !rx_valid);
		wait (expected_fixes.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_fixes.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
